// ===== hdl/kpd_pkg.sv =====
// Shared types, widths and constants of the keyframe PD setpoint player.
`default_nettype none

package kpd_pkg;

   // Field widths.
   localparam int TIME_W  = 24;
   localparam int ANG_W   = 16;
   localparam int GAIN_W  = 24;
   localparam int STEP_W  = 16;
   localparam int CNT_W   = 5;
   localparam int IDX_W   = 4;
   localparam int FRAC_W  = 16;
   localparam int T_W     = FRAC_W + 1;
   localparam int CSR_A_W = 2;
   localparam int CSR_D_W = 16;

   // Default sizes of the key table.
   localparam int DEF_MAX_KEYS   = 16;
   localparam int DEF_MAX_JOINTS = 16;

   // Input item modes.
   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_TICK  = 1'b1;

   // Configuration register indexes.
   localparam logic [CSR_A_W-1:0] CSR_KEY_COUNT   = 2'd0;
   localparam logic [CSR_A_W-1:0] CSR_JOINT_COUNT = 2'd1;
   localparam logic [CSR_A_W-1:0] CSR_TICK_STEP   = 2'd2;

   // Reset values.
   localparam logic [CNT_W-1:0]  KEY_COUNT_RST   = 5'd0;
   localparam logic [CNT_W-1:0]  JOINT_COUNT_RST = 5'd16;
   localparam logic [STEP_W-1:0] TICK_STEP_RST   = 16'd655;
   localparam logic [TIME_W-1:0] DUR_RST         = 24'd13107;
   localparam logic [GAIN_W-1:0] P_RST           = 24'd25600;
   localparam logic [GAIN_W-1:0] D_RST           = 24'd256;
   localparam logic [TIME_W-1:0] TIME_MAX        = {TIME_W{1'b1}};
   localparam logic [T_W-1:0]    T_ONE           = 17'h10000;

   // One input item.
   typedef struct packed {
      logic              mode;
      logic [IDX_W-1:0]  key_index;
      logic [IDX_W-1:0]  joint_index;
      logic [TIME_W-1:0] duration;
      logic signed [ANG_W-1:0] angle;
      logic [GAIN_W-1:0] p_gain;
      logic [GAIN_W-1:0] d_gain;
   } req_type;

   // One result item.
   typedef struct packed {
      logic [IDX_W-1:0]  joint_number;
      logic signed [ANG_W-1:0] angle_setpoint;
      logic [GAIN_W-1:0] p_setpoint;
      logic [GAIN_W-1:0] d_setpoint;
      logic              last;
   } rsp_type;

   // One key table entry for one joint.
   typedef struct packed {
      logic [ANG_W-1:0]  angle;
      logic [GAIN_W-1:0] p_gain;
      logic [GAIN_W-1:0] d_gain;
   } ent_type;

   localparam ent_type ENT_RST = '{angle: '0, p_gain: P_RST, d_gain: D_RST};

endpackage

`default_nettype wire

// ===== hdl/kpd_if.sv =====
// Valid/ready channel interfaces for requests and setpoint results.
`default_nettype none

interface kpd_req_if import kpd_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface kpd_rsp_if import kpd_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/kpd_table.sv =====
// Key table memories (durations and per-joint entries) with a clearing pass after reset.
`default_nettype none

module kpd_table import kpd_pkg::*; #(
   parameter int MAX_KEYS   = DEF_MAX_KEYS,
   parameter int MAX_JOINTS = DEF_MAX_JOINTS,
   localparam int DEPTH = MAX_KEYS * MAX_JOINTS,
   localparam int AW    = $clog2(DEPTH),
   localparam int KW    = $clog2(MAX_KEYS)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              wr_en,
   input  wire logic [AW-1:0]     wr_addr,
   input  wire logic [KW-1:0]     wr_key,
   input  wire logic [TIME_W-1:0] wr_dur,
   input  wire ent_type           wr_ent,
   input  wire logic [KW-1:0]     rd_key,
   input  wire logic [AW-1:0]     rd_addr,
   output      logic [TIME_W-1:0] dur_q,
   output      ent_type           ent_q,
   output      logic              clearing
);

   logic [TIME_W-1:0] dur_mem [MAX_KEYS];
   ent_type           ent_mem [DEPTH];

   logic          clearing_ff, clearing_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;
   logic [TIME_W-1:0] dur_q_ff;
   ent_type           ent_q_ff;

   // Clearing sweep, one entry per cycle.
   always_comb begin
      clearing_in = clearing_ff;
      clr_addr_in = clr_addr_ff;
      if (clearing_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == AW'(DEPTH - 1)) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clearing_ff <= clearing_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // Entry memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         ent_mem[clr_addr_ff] <= ENT_RST;
      end else if (wr_en) begin
         ent_mem[wr_addr] <= wr_ent;
      end
      ent_q_ff <= ent_mem[rd_addr];
   end

   // Duration memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         if ({1'b0, clr_addr_ff} < (AW + 1)'(MAX_KEYS)) begin
            dur_mem[clr_addr_ff[KW-1:0]] <= DUR_RST;
         end
      end else if (wr_en) begin
         dur_mem[wr_key] <= wr_dur;
      end
      dur_q_ff <= dur_mem[rd_key];
   end

   assign dur_q    = dur_q_ff;
   assign ent_q    = ent_q_ff;
   assign clearing = clearing_ff;

endmodule

`default_nettype wire

// ===== hdl/kpd_div.sv =====
// Restoring divider that yields the fraction (num << 16) / den, one bit per cycle.
`default_nettype none

module kpd_div import kpd_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [TIME_W-1:0] num,
   input  wire logic [TIME_W-1:0] den,
   output      logic              busy,
   output      logic [FRAC_W-1:0] quo
);

   localparam int CW = $clog2(FRAC_W);

   logic              busy_ff, busy_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [TIME_W:0]   rem_ff, rem_in;
   logic [TIME_W-1:0] den_ff, den_in;
   logic [FRAC_W-1:0] quo_ff, quo_in;
   logic [TIME_W:0]   shifted;
   logic              fits;

   // One quotient bit per cycle; the numerator is always below the divisor.
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      shifted = {rem_ff[TIME_W-1:0], 1'b0};
      fits    = shifted >= {1'b0, den_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = {1'b0, num};
         den_in  = den;
      end else if (busy_ff) begin
         rem_in = fits ? (shifted - {1'b0, den_ff}) : shifted;
         quo_in = {quo_ff[FRAC_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(FRAC_W - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign busy = busy_ff;
   assign quo  = quo_ff;

endmodule

`default_nettype wire

// ===== hdl/kpd_mac.sv =====
// Shared blend unit: registered (cur - prev) * t, then prev + rounded product.
`default_nettype none

module kpd_mac import kpd_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     load,
   input  wire logic signed [GAIN_W:0]   diff,
   input  wire logic [T_W-1:0]           t,
   input  wire logic [GAIN_W-1:0]        base,
   output      logic [GAIN_W-1:0]        result
);

   localparam int PW = GAIN_W + 1 + T_W + 1;

   logic signed [PW-1:0] prod_ff;
   logic signed [PW-1:0] sum;

   // Product register between the multiply and the add.
   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff <= diff * $signed({1'b0, t});
      end
   end

   // Add the previous value scaled up, round half up and scale back.
   always_comb begin
      sum = $signed({{(PW - GAIN_W - FRAC_W){1'b0}}, base, {FRAC_W{1'b0}}})
            + prod_ff + $signed(PW'(T_ONE >> 1));
      result = sum[GAIN_W+FRAC_W-1:FRAC_W];
   end

endmodule

`default_nettype wire

// ===== hdl/keyframe_pd_setpoint_player_top.sv =====
// Top level of the keyframe PD setpoint player: sequencer, registers and channels.
//
// Requests arrive on req_if. A write request stores one key entry (duration plus one
// joint's angle, P and D gain) and is done in the cycle it is taken; it yields no
// result. A tick request with a nonzero key count blends every joint's setpoint between
// the previous and the current key and returns one result per joint on rsp_if, the final
// one with last set. The configuration port (csr_we, csr_index, csr_wdata) sets key count,
// joint count and tick step; the user must write it only while the block is idle, which
// the block does not enforce. A tick reads the key duration, divides for the fraction when
// the key is still running, then per joint reads the previous and current entries and
// blends angle, P and D, then advances time and sums the key durations when the cycle wraps.
// The single table read port and the one shared multiplier, which serves angle, P and D in
// turn, set the per-joint sequence. req_if.ready is high only while the sequencer is idle.
// After reset the key tables are swept to their reset values, one entry per cycle over all
// MAX_KEYS * MAX_JOINTS entries; requests are held off meanwhile.
// Each result sits in an output register until the receiver takes it; a stalled
// receiver simply holds the sequencer.
`default_nettype none

module keyframe_pd_setpoint_player_top import kpd_pkg::*; #(
   parameter int MAX_KEYS   = DEF_MAX_KEYS,
   parameter int MAX_JOINTS = DEF_MAX_JOINTS
) (
   input  wire logic               clock,
   input  wire logic               reset,
   kpd_req_if.sink                 req_if,
   kpd_rsp_if.source               rsp_if,
   input  wire logic               csr_we,
   input  wire logic [CSR_A_W-1:0] csr_index,
   input  wire logic [CSR_D_W-1:0] csr_wdata
);

   localparam int DEPTH = MAX_KEYS * MAX_JOINTS;
   localparam int AW    = $clog2(DEPTH);
   localparam int KW    = $clog2(MAX_KEYS);
   localparam int JW    = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
   localparam int NKW   = $clog2(MAX_KEYS + 1);
   localparam int NJW   = $clog2(MAX_JOINTS + 1);
   localparam int TOT_W = TIME_W + NKW;
   localparam logic [AW-1:0] MJ_A = AW'(MAX_JOINTS);

   // Sequencer states.
   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_DRD   = 4'd2;
   localparam logic [3:0] S_DCHK  = 4'd3;
   localparam logic [3:0] S_DIV   = 4'd4;
   localparam logic [3:0] S_RDP   = 4'd5;
   localparam logic [3:0] S_RDC   = 4'd6;
   localparam logic [3:0] S_LAT   = 4'd7;
   localparam logic [3:0] S_MA    = 4'd8;
   localparam logic [3:0] S_MP    = 4'd9;
   localparam logic [3:0] S_MD    = 4'd10;
   localparam logic [3:0] S_MF    = 4'd11;
   localparam logic [3:0] S_OUT   = 4'd12;
   localparam logic [3:0] S_ADV   = 4'd13;
   localparam logic [3:0] S_SRD   = 4'd14;
   localparam logic [3:0] S_SACC  = 4'd15;

   logic [3:0]        state_ff, state_in;
   logic [CNT_W-1:0]  key_count_ff, key_count_in;
   logic [CNT_W-1:0]  joint_count_ff, joint_count_in;
   logic [STEP_W-1:0] tick_step_ff, tick_step_in;
   logic [KW-1:0]     cur_ff, cur_in;
   logic [TIME_W-1:0] elapsed_ff, elapsed_in;
   logic [TIME_W-1:0] phase_ff, phase_in;
   logic [NKW-1:0]    nk_ff, nk_in;
   logic [NJW-1:0]    nj_ff, nj_in;
   logic [NJW-1:0]    j_ff, j_in;
   logic [KW-1:0]     idx_ff, idx_in;
   logic [TIME_W-1:0] dur_ff, dur_in;
   logic [T_W-1:0]    t_ff, t_in;
   logic [TOT_W-1:0]  total_ff, total_in;
   logic              wrap_ff, wrap_in;
   ent_type           prev_ent_ff, prev_ent_in;
   ent_type           cur_ent_ff, cur_ent_in;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic              req_acc;
   logic              wr_ok;
   logic [NKW-1:0]    nk_now;
   logic [NJW-1:0]    nj_now;
   logic [KW-1:0]     prev_key;
   logic [TIME_W-1:0] rel;
   logic [TIME_W:0]   e_sum;
   logic [TIME_W-1:0] e_sat;
   logic [TIME_W:0]   end_t;
   logic [TOT_W-1:0]  e_ext;

   logic              tbl_wr_en;
   logic [AW-1:0]     tbl_wr_addr;
   logic [KW-1:0]     tbl_rd_key;
   logic [AW-1:0]     tbl_rd_addr;
   logic [TIME_W-1:0] tbl_dur_q;
   ent_type           tbl_ent_q;
   ent_type           tbl_wr_ent;
   logic              tbl_clearing;

   logic              div_start;
   logic              div_busy;
   logic [FRAC_W-1:0] div_quo;

   logic                   mac_load;
   logic signed [GAIN_W:0] mac_diff;
   logic [GAIN_W-1:0]      mac_base;
   logic [GAIN_W-1:0]      mac_result;
   logic [GAIN_W-1:0]      prev_ang_u, cur_ang_u;

   // Request transfer and table writes.
   assign req_if.ready = (state_ff == S_IDLE);
   assign req_acc      = req_if.valid && req_if.ready;
   assign wr_ok        = (32'(req_if.data.key_index) < MAX_KEYS)
                         && (32'(req_if.data.joint_index) < MAX_JOINTS);
   assign tbl_wr_en    = req_acc && (req_if.data.mode == MODE_WRITE) && wr_ok;
   assign tbl_wr_addr  = AW'(KW'(req_if.data.key_index)) * MJ_A
                         + AW'(JW'(req_if.data.joint_index));
   assign tbl_wr_ent   = '{angle: req_if.data.angle, p_gain: req_if.data.p_gain,
                           d_gain: req_if.data.d_gain};

   // Effective key and joint counts.
   assign nk_now = (32'(key_count_ff) > MAX_KEYS) ? NKW'(MAX_KEYS) : NKW'(key_count_ff);
   assign nj_now = (32'(joint_count_ff) > MAX_JOINTS) ? NJW'(MAX_JOINTS)
                                                      : NJW'(joint_count_ff);
   assign prev_key = (cur_ff == '0) ? KW'(nk_ff - 1'b1) : (cur_ff - 1'b1);

   // Table read addresses follow the sequencer.
   assign tbl_rd_key  = ((state_ff == S_SRD) || (state_ff == S_SACC)) ? idx_ff : cur_ff;
   assign tbl_rd_addr = ((state_ff == S_RDP) ? AW'(prev_key) : AW'(cur_ff)) * MJ_A
                        + AW'(j_ff[JW-1:0]);

   // Time arithmetic.
   assign rel   = (elapsed_ff > phase_ff) ? (elapsed_ff - phase_ff) : '0;
   assign e_sum = {1'b0, elapsed_ff} + (TIME_W + 1)'(tick_step_ff);
   assign e_sat = e_sum[TIME_W] ? TIME_MAX : e_sum[TIME_W-1:0];
   assign end_t = {1'b0, phase_ff} + {1'b0, dur_ff};
   assign e_ext = TOT_W'(elapsed_ff);

   // Blend unit operands: angles are offset to unsigned before blending.
   assign prev_ang_u = GAIN_W'(prev_ent_ff.angle ^ 16'h8000);
   assign cur_ang_u  = GAIN_W'(cur_ent_ff.angle ^ 16'h8000);
   assign mac_load   = (state_ff == S_MA) || (state_ff == S_MP) || (state_ff == S_MD);

   always_comb begin
      case (state_ff)
         S_MA: begin
            mac_diff = $signed({1'b0, cur_ang_u}) - $signed({1'b0, prev_ang_u});
            mac_base = prev_ang_u;
         end
         S_MP: begin
            mac_diff = $signed({1'b0, cur_ent_ff.p_gain}) - $signed({1'b0, prev_ent_ff.p_gain});
            mac_base = prev_ang_u;
         end
         S_MD: begin
            mac_diff = $signed({1'b0, cur_ent_ff.d_gain}) - $signed({1'b0, prev_ent_ff.d_gain});
            mac_base = prev_ent_ff.p_gain;
         end
         default: begin
            mac_diff = '0;
            mac_base = prev_ent_ff.d_gain;
         end
      endcase
   end

   // Sequencer.
   always_comb begin
      state_in       = state_ff;
      key_count_in   = key_count_ff;
      joint_count_in = joint_count_ff;
      tick_step_in   = tick_step_ff;
      cur_in         = cur_ff;
      elapsed_in     = elapsed_ff;
      phase_in       = phase_ff;
      nk_in          = nk_ff;
      nj_in          = nj_ff;
      j_in           = j_ff;
      idx_in         = idx_ff;
      dur_in         = dur_ff;
      t_in           = t_ff;
      total_in       = total_ff;
      wrap_in        = wrap_ff;
      prev_ent_in    = prev_ent_ff;
      cur_ent_in     = cur_ent_ff;
      rsp_in         = rsp_ff;
      rsp_valid_in   = rsp_valid_ff;
      div_start      = 1'b0;

      // Configuration writes.
      if (csr_we) begin
         case (csr_index)
            CSR_KEY_COUNT:   key_count_in   = csr_wdata[CNT_W-1:0];
            CSR_JOINT_COUNT: joint_count_in = csr_wdata[CNT_W-1:0];
            CSR_TICK_STEP:   tick_step_in   = csr_wdata[STEP_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_CLEAR: begin
            if (!tbl_clearing) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_acc && (req_if.data.mode == MODE_TICK) && (nk_now != '0)) begin
               nk_in = nk_now;
               nj_in = nj_now;
               if (NKW'(cur_ff) >= nk_now) begin
                  cur_in     = '0;
                  phase_in   = '0;
                  elapsed_in = '0;
               end
               state_in = S_DRD;
            end
         end
         S_DRD: begin
            state_in = S_DCHK;
         end
         S_DCHK: begin
            dur_in = tbl_dur_q;
            j_in   = '0;
            if ((tbl_dur_q == '0) || (rel >= tbl_dur_q)) begin
               t_in     = T_ONE;
               state_in = (nj_ff == '0) ? S_ADV : S_RDP;
            end else begin
               div_start = 1'b1;
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            if (!div_busy) begin
               t_in     = {1'b0, div_quo};
               state_in = (nj_ff == '0) ? S_ADV : S_RDP;
            end
         end
         S_RDP: begin
            state_in = S_RDC;
         end
         S_RDC: begin
            prev_ent_in = tbl_ent_q;
            state_in    = S_LAT;
         end
         S_LAT: begin
            cur_ent_in = tbl_ent_q;
            state_in   = S_MA;
         end
         S_MA: begin
            state_in = S_MP;
         end
         S_MP: begin
            rsp_in.angle_setpoint = mac_result[ANG_W-1:0] ^ 16'h8000;
            state_in = S_MD;
         end
         S_MD: begin
            rsp_in.p_setpoint = mac_result;
            state_in = S_MF;
         end
         S_MF: begin
            rsp_in.d_setpoint   = mac_result;
            rsp_in.joint_number = IDX_W'(j_ff);
            rsp_in.last         = ((j_ff + 1'b1) == nj_ff);
            rsp_valid_in        = 1'b1;
            state_in            = S_OUT;
         end
         S_OUT: begin
            if (rsp_if.ready) begin
               rsp_valid_in = 1'b0;
               if ((j_ff + 1'b1) == nj_ff) begin
                  state_in = S_ADV;
               end else begin
                  j_in     = j_ff + 1'b1;
                  state_in = S_RDP;
               end
            end
         end
         S_ADV: begin
            elapsed_in = e_sat;
            state_in   = S_IDLE;
            wrap_in    = 1'b0;
            if ({1'b0, e_sat} > end_t) begin
               phase_in = end_t[TIME_W] ? TIME_MAX : end_t[TIME_W-1:0];
               if ((NKW'(cur_ff) + 1'b1) >= nk_ff) begin
                  idx_in   = '0;
                  total_in = '0;
                  state_in = S_SRD;
               end else begin
                  cur_in = cur_ff + 1'b1;
               end
            end
         end
         S_SRD: begin
            wrap_in  = 1'b0;
            state_in = S_SACC;
         end
         S_SACC: begin
            if (!wrap_ff) begin
               total_in = total_ff + TOT_W'(tbl_dur_q);
               if ((NKW'(idx_ff) + 1'b1) == nk_ff) begin
                  wrap_in = 1'b1;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_SRD;
               end
            end else begin
               // Whole cycle done: wrap time by the total duration.
               elapsed_in = (e_ext > total_ff) ? TIME_W'(e_ext - total_ff) : '0;
               phase_in   = '0;
               cur_in     = '0;
               wrap_in    = 1'b0;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLEAR;
         key_count_ff   <= KEY_COUNT_RST;
         joint_count_ff <= JOINT_COUNT_RST;
         tick_step_ff   <= TICK_STEP_RST;
         cur_ff         <= '0;
         elapsed_ff     <= '0;
         phase_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
         wrap_ff        <= 1'b0;
      end else begin
         state_ff       <= state_in;
         key_count_ff   <= key_count_in;
         joint_count_ff <= joint_count_in;
         tick_step_ff   <= tick_step_in;
         cur_ff         <= cur_in;
         elapsed_ff     <= elapsed_in;
         phase_ff       <= phase_in;
         rsp_valid_ff   <= rsp_valid_in;
         wrap_ff        <= wrap_in;
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      nk_ff       <= nk_in;
      nj_ff       <= nj_in;
      j_ff        <= j_in;
      idx_ff      <= idx_in;
      dur_ff      <= dur_in;
      t_ff        <= t_in;
      total_ff    <= total_in;
      prev_ent_ff <= prev_ent_in;
      cur_ent_ff  <= cur_ent_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.data  = rsp_ff;

   kpd_table #(
      .MAX_KEYS   (MAX_KEYS),
      .MAX_JOINTS (MAX_JOINTS)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (tbl_wr_en),
      .wr_addr  (tbl_wr_addr),
      .wr_key   (KW'(req_if.data.key_index)),
      .wr_dur   (req_if.data.duration),
      .wr_ent   (tbl_wr_ent),
      .rd_key   (tbl_rd_key),
      .rd_addr  (tbl_rd_addr),
      .dur_q    (tbl_dur_q),
      .ent_q    (tbl_ent_q),
      .clearing (tbl_clearing)
   );

   kpd_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (rel),
      .den   (tbl_dur_q),
      .busy  (div_busy),
      .quo   (div_quo)
   );

   kpd_mac u_mac (
      .clock  (clock),
      .load   (mac_load),
      .diff   (mac_diff),
      .t      (t_ff),
      .base   (mac_base),
      .result (mac_result)
   );

endmodule

`default_nettype wire
